// ===== hw/rtl/tnau_pkg.sv =====
// ----------------------------------------------------------------------------
// tnau_pkg: shared types and constants
// Field widths, parameter defaults and the control word that travels with
// each triangle through the arithmetic pipeline.
// ----------------------------------------------------------------------------
package tnau_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORMAL_FRAC_DEF = 14;

    localparam int TAG_W   = 16;
    localparam int AREA_W  = 33;
    localparam int NORM_W  = 16;
    localparam int THR_W   = 16;
    localparam int THRSQ_W = 2 * THR_W;

    // per-triangle side data carried alongside the datapath
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       neg;    // sign of each cross component, x in bit 0
        logic             degen;
    } ctl_t;

endpackage

// ===== hw/rtl/tnau_front.sv =====
// ----------------------------------------------------------------------------
// tnau_front: edges, cross product and squared length
// Seven register stages: edges, products, cross/abs, split squares,
// squares, squared length, degenerate test.
// ----------------------------------------------------------------------------
module tnau_front #(
    parameter int CW = tnau_pkg::COORD_WIDTH_DEF,
    localparam int EW  = CW + 1,
    localparam int PW  = 2 * EW,
    localparam int XW  = PW + 1,
    localparam int MW  = 2 * EW,
    localparam int LH  = (MW + 1) / 2,
    localparam int HH  = MW - LH,
    localparam int SQW = 2 * MW,
    localparam int SW  = 2 * MW + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tnau_pkg::TAG_W-1:0]   in_tag,
    input  logic [CW-1:0]                in_a [3],
    input  logic [CW-1:0]                in_b [3],
    input  logic [CW-1:0]                in_c [3],
    input  logic [tnau_pkg::THRSQ_W-1:0] thr_sq,
    output logic                         out_valid,
    output tnau_pkg::ctl_t               out_ctl,
    output logic [SQW-1:0]               out_m2 [3],
    output logic [SW-1:0]                out_s
);

    logic [6:0]                 v_reg;
    logic [tnau_pkg::TAG_W-1:0] tag_reg [7];
    logic [2:0]                 neg_reg [5];
    logic [2:0]                 neg_next;

    logic signed [EW-1:0] e1_reg [3], e2_reg [3], e1_next [3], e2_next [3];
    logic signed [PW-1:0] p_reg [6], p_next [6];
    logic signed [XW-1:0] x_w [3], a_w [3];
    logic [MW-1:0]        mag_reg [3], mag_next [3];
    logic [2*LH-1:0]      ll_reg [3], ll_next [3];
    logic [MW-1:0]        lh_reg [3], lh_next [3];
    logic [2*HH-1:0]      hh_reg [3], hh_next [3];
    logic [SQW-1:0]       m2_reg [3], m2b_reg [3], m2c_reg [3], m2_next [3];
    logic [SW-1:0]        s_reg, s2_reg, s_next;
    logic                 dg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_comb begin
        logic [LH-1:0] lo;
        logic [HH-1:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < 3; i++) begin
            e1_next[i] = {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
            e2_next[i] = {in_c[i][CW-1], in_c[i]} - {in_a[i][CW-1], in_a[i]};
        end
        // x = 0, y = 1, z = 2
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++) begin
            x_w[i]      = XW'(p_reg[2*i]) - XW'(p_reg[2*i+1]);
            neg_next[i] = x_w[i][XW-1];
            a_w[i]      = x_w[i][XW-1] ? -x_w[i] : x_w[i];
            mag_next[i] = a_w[i][MW-1:0];
            // square split in halves to keep each multiplier narrow
            lo          = mag_reg[i][LH-1:0];
            hi          = mag_reg[i][MW-1:LH];
            ll_next[i]  = (2*LH)'(lo) * (2*LH)'(lo);
            lh_next[i]  = MW'(lo) * MW'(hi);
            hh_next[i]  = (2*HH)'(hi) * (2*HH)'(hi);
            m2_next[i]  = (SQW'(hh_reg[i]) << (2*LH)) + (SQW'(lh_reg[i]) << (LH+1))
                        + SQW'(ll_reg[i]);
        end
        s_next = SW'(m2_reg[0]) + SW'(m2_reg[1]) + SW'(m2_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < 7; k++) tag_reg[k] <= tag_reg[k-1];
            neg_reg[0] <= neg_next;
            for (int k = 1; k < 5; k++) neg_reg[k] <= neg_reg[k-1];
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            p_reg   <= p_next;
            mag_reg <= mag_next;
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            hh_reg  <= hh_next;
            m2_reg  <= m2_next;
            m2b_reg <= m2_reg;
            m2c_reg <= m2b_reg;
            s_reg   <= s_next;
            s2_reg  <= s_reg;
            dg_reg  <= (s_reg <= SW'(thr_sq));
        end
    end

    always_comb begin
        out_valid     = v_reg[6];
        out_ctl.tag   = tag_reg[6];
        out_ctl.neg   = neg_reg[4];
        out_ctl.degen = dg_reg;
        out_m2        = m2c_reg;
        out_s         = s2_reg;
    end

endmodule

// ===== hw/rtl/tnau_div.sv =====
// ----------------------------------------------------------------------------
// tnau_div: pipelined restoring divider, three lanes, shared divisor
// One quotient bit per stage, numerator known not to exceed the divisor;
// the quotient covers numerator * 2^(QW-1) / divisor.
// ----------------------------------------------------------------------------
module tnau_div #(
    parameter int SQW = 68,
    parameter int SW  = 70,
    parameter int QW  = 29,
    localparam int RMW = SW + 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  tnau_pkg::ctl_t in_ctl,
    input  logic [SQW-1:0] in_num [3],
    input  logic [SW-1:0]  in_den,
    output logic           out_valid,
    output tnau_pkg::ctl_t out_ctl,
    output logic [QW-1:0]  out_q [3],
    output logic [SW-1:0]  out_den
);

    logic [QW-1:0]   v_reg;
    tnau_pkg::ctl_t  ctl_reg [QW];
    logic [SW-1:0]   den_reg [QW];
    logic [RMW-1:0]  rem_reg [QW][3];
    logic [QW-1:0]   q_reg [QW][3];

    logic [SW-1:0]   src_den [QW];
    logic [RMW-1:0]  src_rem [QW][3];
    logic [QW-1:0]   src_q [QW][3];
    logic            ge [QW][3];
    logic [RMW-1:0]  dif [QW][3];
    logic [RMW-1:0]  nrem [QW][3];
    logic [QW-1:0]   nq [QW][3];

    for (genvar k = 0; k < QW; k++) begin : g_step
        if (k == 0) begin : g_first
            assign src_den[k] = in_den;
        end else begin : g_next
            assign src_den[k] = den_reg[k-1];
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            if (k == 0) begin : g_first
                assign src_rem[k][l] = RMW'(in_num[l]);
                assign src_q[k][l]   = '0;
            end else begin : g_next
                assign src_rem[k][l] = rem_reg[k-1][l];
                assign src_q[k][l]   = q_reg[k-1][l];
            end
            assign ge[k][l]   = src_rem[k][l] >= {1'b0, src_den[k]};
            assign dif[k][l]  = ge[k][l] ? src_rem[k][l] - {1'b0, src_den[k]}
                                         : src_rem[k][l];
            assign nrem[k][l] = {dif[k][l][RMW-2:0], 1'b0};
            assign nq[k][l]   = {src_q[k][l][QW-2:0], ge[k][l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int k = 0; k < QW; k++) begin
                if (k > 0) ctl_reg[k] <= ctl_reg[k-1];
                den_reg[k] <= src_den[k];
                rem_reg[k] <= nrem[k];
                q_reg[k]   <= nq[k];
            end
        end
    end

    always_comb begin
        out_valid = v_reg[QW-1];
        out_ctl   = ctl_reg[QW-1];
        out_q     = q_reg[QW-1];
        out_den   = den_reg[QW-1];
    end

endmodule

// ===== hw/rtl/tnau_sqrt.sv =====
// ----------------------------------------------------------------------------
// tnau_sqrt: pipelined integer square root
// Digit-by-digit, one root bit per stage, LANES radicands in lockstep with
// a side payload that rides along unchanged.
// ----------------------------------------------------------------------------
module tnau_sqrt #(
    parameter int LANES = 1,
    parameter int W     = 70,
    parameter int PLW   = 20,
    localparam int RTW = W / 2,
    localparam int RMW = RTW + 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [PLW-1:0]  in_pl,
    input  logic [W-1:0]    in_rad [LANES],
    output logic            out_valid,
    output logic [PLW-1:0]  out_pl,
    output logic [RTW-1:0]  out_root [LANES]
);

    logic [RTW-1:0] v_reg;
    logic [PLW-1:0] pl_reg [RTW];
    logic [W-1:0]   rad_reg [RTW][LANES];
    logic [RMW-1:0] rem_reg [RTW][LANES];
    logic [RTW-1:0] root_reg [RTW][LANES];

    logic [W-1:0]   src_rad [RTW][LANES];
    logic [RMW-1:0] src_rem [RTW][LANES];
    logic [RTW-1:0] src_root [RTW][LANES];
    logic [RMW-1:0] cat [RTW][LANES];
    logic [RMW-1:0] trial [RTW][LANES];
    logic           ge [RTW][LANES];
    logic [RMW-1:0] nrem [RTW][LANES];
    logic [RTW-1:0] nroot [RTW][LANES];
    logic [W-1:0]   nrad [RTW][LANES];

    for (genvar k = 0; k < RTW; k++) begin : g_step
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (k == 0) begin : g_first
                assign src_rad[k][l]  = in_rad[l];
                assign src_rem[k][l]  = '0;
                assign src_root[k][l] = '0;
            end else begin : g_next
                assign src_rad[k][l]  = rad_reg[k-1][l];
                assign src_rem[k][l]  = rem_reg[k-1][l];
                assign src_root[k][l] = root_reg[k-1][l];
            end
            // remainder never exceeds twice the partial root, so its top bits are free
            assign cat[k][l]   = {src_rem[k][l][RMW-3:0], src_rad[k][l][W-1:W-2]};
            assign trial[k][l] = {src_root[k][l], 2'b01};
            assign ge[k][l]    = cat[k][l] >= trial[k][l];
            assign nrem[k][l]  = ge[k][l] ? cat[k][l] - trial[k][l] : cat[k][l];
            assign nroot[k][l] = {src_root[k][l][RTW-2:0], ge[k][l]};
            assign nrad[k][l]  = {src_rad[k][l][W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[RTW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg[0] <= in_pl;
            for (int k = 0; k < RTW; k++) begin
                if (k > 0) pl_reg[k] <= pl_reg[k-1];
                rad_reg[k]  <= nrad[k];
                rem_reg[k]  <= nrem[k];
                root_reg[k] <= nroot[k];
            end
        end
    end

    always_comb begin
        out_valid = v_reg[RTW-1];
        out_pl    = pl_reg[RTW-1];
        out_root  = root_reg[RTW-1];
    end

endmodule

// ===== hw/rtl/triangle_normal_and_area_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_normal_and_area_unit: triangle area and unit normal
// Cross product of the edges, area as half its length, normal in Q1.F.
// ----------------------------------------------------------------------------
// Usage
//   s_* stream: one triangle per transaction, tag and nine vertex coordinates.
//   m_* stream: one result per triangle, in arrival order: tag, area, normal,
//   and the degenerate flag in m_tuser.
//   cfg_*: writes the degenerate threshold (cross length units); always ready.
//   Write it only while no triangle is in flight.
// Throughput: one triangle per cycle, sustained while m_tready takes each result.
// Pipeline: the bit-per-stage units are a (2*NORMAL_FRAC+1)-stage divider, a
//   (2*COORD_WIDTH+3)-stage root of the squared length and a (NORMAL_FRAC+1)-stage
//   root for the normal, behind seven stages of edge, cross product and squaring
//   arithmetic.
// Stall: the whole pipeline freezes while the output register holds a result
//   that m_tready does not take; s_tready falls at the same time, nothing is
//   dropped or repeated.
// Reset: clears all valid flags and the threshold to zero.
// ----------------------------------------------------------------------------
module triangle_normal_and_area_unit #(
    parameter int COORD_WIDTH = tnau_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC = tnau_pkg::NORMAL_FRAC_DEF,
    localparam int IN_W      = tnau_pkg::TAG_W + 9 * COORD_WIDTH,
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = tnau_pkg::TAG_W + tnau_pkg::AREA_W + 3 * tnau_pkg::NORM_W,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // triangle_tag, ax, ay, az, bx, by, bz, cx, cy, cz, zero fill
    input  logic [S_TDATA_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // tag_out, area, normal_x, normal_y, normal_z, zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // degenerate
    output logic [0:0]                 m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tnau_pkg::THR_W-1:0] cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int NF   = NORMAL_FRAC;
    localparam int MW   = 2 * (CW + 1);
    localparam int SQW  = 2 * MW;
    localparam int SW   = 2 * MW + 2;
    localparam int RW   = SW / 2;
    localparam int QW   = 2 * NF + 1;
    localparam int QSW  = QW + 1;
    localparam int NRW  = QSW / 2;
    localparam int NXW  = NF + 2;
    localparam int CTLW = $bits(tnau_pkg::ctl_t);
    localparam int PL1W = CTLW + 3 * QW;
    localparam int PL2W = CTLW + RW;
    localparam int NW   = tnau_pkg::NORM_W;
    localparam logic [NXW-1:0] ONE_N = {2'b01, {NF{1'b0}}};

    logic                          en;
    logic [tnau_pkg::THR_W-1:0]    thr_reg;
    logic [tnau_pkg::THRSQ_W-1:0]  thr_sq_reg;

    logic [CW-1:0]  crd_a [3], crd_b [3], crd_c [3];

    logic           f_valid;
    tnau_pkg::ctl_t f_ctl;
    logic [SQW-1:0] f_m2 [3];
    logic [SW-1:0]  f_s;

    logic           d_valid;
    tnau_pkg::ctl_t d_ctl;
    logic [QW-1:0]  d_q [3];
    logic [SW-1:0]  d_s;
    logic [SW-1:0]  d_rad [1];

    logic           r_valid;
    logic [PL1W-1:0] r_pl_in, r_pl;
    logic [RW-1:0]  r_root [1];

    logic           n_valid;
    logic [PL2W-1:0] n_pl_in, n_pl;
    logic [QSW-1:0] n_rad [3];
    logic [NRW-1:0] n_root [3];

    tnau_pkg::ctl_t                  fin_ctl;
    logic [RW-1:0]                   fin_root;
    logic [NXW-1:0]                  sv [3];
    logic [NXW+NW-1:0]               ext [3];
    logic [NW-1:0]                   norm_next [3];
    logic [RW+tnau_pkg::AREA_W-1:0]  area_full;

    logic                            m_valid_reg;
    logic [tnau_pkg::TAG_W-1:0]      tag_out_reg;
    logic [tnau_pkg::AREA_W-1:0]     area_reg;
    logic [NW-1:0]                   norm_reg [3];
    logic                            degen_reg;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= '0;
            thr_sq_reg <= '0;
        end else begin
            if (cfg_valid) thr_reg <= cfg_data;
            thr_sq_reg <= tnau_pkg::THRSQ_W'(thr_reg) * tnau_pkg::THRSQ_W'(thr_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            crd_a[i] = s_tdata[tnau_pkg::TAG_W + i*CW +: CW];
            crd_b[i] = s_tdata[tnau_pkg::TAG_W + (i+3)*CW +: CW];
            crd_c[i] = s_tdata[tnau_pkg::TAG_W + (i+6)*CW +: CW];
        end
    end

    tnau_front #(.CW(CW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_tag    (s_tdata[tnau_pkg::TAG_W-1:0]),
        .in_a      (crd_a),
        .in_b      (crd_b),
        .in_c      (crd_c),
        .thr_sq    (thr_sq_reg),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_m2    (f_m2),
        .out_s     (f_s)
    );

    // squared normal component: m^2 * 2^(2F) / S
    tnau_div #(.SQW(SQW), .SW(SW), .QW(QW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_ctl    (f_ctl),
        .in_num    (f_m2),
        .in_den    (f_s),
        .out_valid (d_valid),
        .out_ctl   (d_ctl),
        .out_q     (d_q),
        .out_den   (d_s)
    );

    assign d_rad[0] = d_s;
    assign r_pl_in  = {d_q[2], d_q[1], d_q[0], d_ctl};

    tnau_sqrt #(.LANES(1), .W(SW), .PLW(PL1W)) u_sqrt_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_pl     (r_pl_in),
        .in_rad    (d_rad),
        .out_valid (r_valid),
        .out_pl    (r_pl),
        .out_root  (r_root)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rad[l] = {1'b0, r_pl[CTLW + l*QW +: QW]};
        end
        n_pl_in = {r_root[0], r_pl[CTLW-1:0]};
    end

    tnau_sqrt #(.LANES(3), .W(QSW), .PLW(PL2W)) u_sqrt_nrm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_pl     (n_pl_in),
        .in_rad    (n_rad),
        .out_valid (n_valid),
        .out_pl    (n_pl),
        .out_root  (n_root)
    );

    always_comb begin
        fin_ctl   = n_pl[CTLW-1:0];
        fin_root  = n_pl[CTLW +: RW];
        area_full = {{tnau_pkg::AREA_W{1'b0}}, fin_root};
        for (int l = 0; l < 3; l++) begin
            if (fin_ctl.degen) begin
                sv[l] = (l == 2) ? ONE_N : '0;
            end else begin
                sv[l] = fin_ctl.neg[l] ? -{1'b0, n_root[l]} : {1'b0, n_root[l]};
            end
            ext[l]       = {{NW{sv[l][NXW-1]}}, sv[l]};
            norm_next[l] = ext[l][NW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= n_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_out_reg <= fin_ctl.tag;
            area_reg    <= area_full[tnau_pkg::AREA_W:1];
            norm_reg    <= norm_next;
            degen_reg   <= fin_ctl.degen;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = degen_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, norm_reg[2], norm_reg[1], norm_reg[0],
                       area_reg, tag_out_reg};

    // a degenerate result carries the default normal
    a_degen_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> norm_reg[0] == '0 && norm_reg[1] == '0
                                   && norm_reg[2] == NW'(ONE_N))
        else $error("degenerate result without default normal");

    // threshold square follows a write, registered through thr_reg and then thr_sq_reg
    a_thr_sq: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> ##1
            thr_sq_reg == tnau_pkg::THRSQ_W'($past(cfg_data, 2))
                          * tnau_pkg::THRSQ_W'($past(cfg_data, 2)))
        else $error("threshold square out of step with write");

    // while a result is held back, no new triangle enters and the pipe is frozen
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready ##1 $stable(n_valid))
        else $error("pipeline moved during output stall");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: triangle normal and area unit testbench
// Streams directed and random triangles under several degenerate thresholds,
// predicts area, unit normal and degenerate flag with exact wide arithmetic,
// and checks each result transaction in order under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_W = 160;
    localparam int M_W = 104;

    typedef struct {
        bit [15:0] tag;
        int        crd[9];   // ax ay az bx by bz cx cy cz
    } triangle_t;

    typedef struct {
        bit [15:0] tag;
        bit [32:0] area;
        bit [15:0] nrm[3];
        bit        degen;
    } geom_t;

    class geom_scoreboard;
        geom_t     pending_q[$];
        bit [15:0] threshold;
        int        errors;

        function automatic bit [15:0] unit_comp(longint c, logic [127:0] s);
            logic [127:0] mag, rhs, t;
            bit [15:0]    q;
            mag = (c < 0) ? -c : c;
            rhs = (mag * mag) << 28;
            q = 0;
            for (int b = 14; b >= 0; b--) begin
                t = q | (16'd1 << b);
                if (t * t * s <= rhs) q = t;
            end
            return (c < 0) ? -q : q;
        endfunction

        function automatic geom_t predict_geometry(triangle_t t);
            geom_t        r;
            longint       e[6], x[3];
            logic [127:0] s, m, root, tt;
            for (int i = 0; i < 3; i++) begin
                e[i]     = longint'(t.crd[3 + i]) - t.crd[i];
                e[3 + i] = longint'(t.crd[6 + i]) - t.crd[i];
            end
            x[0] = e[1] * e[5] - e[2] * e[4];
            x[1] = e[2] * e[3] - e[0] * e[5];
            x[2] = e[0] * e[4] - e[1] * e[3];
            s = 0;
            for (int i = 0; i < 3; i++) begin
                m = (x[i] < 0) ? -x[i] : x[i];
                s += m * m;
            end
            root = 0;
            for (int b = 40; b >= 0; b--) begin
                tt = root | (128'd1 << b);
                if (tt * tt <= s) root = tt;
            end
            r.tag   = t.tag;
            r.area  = root >> 1;
            r.degen = (s <= 128'(threshold) * threshold);
            for (int i = 0; i < 3; i++)
                r.nrm[i] = r.degen ? ((i == 2) ? 16'd16384 : 16'd0) : unit_comp(x[i], s);
            return r;
        endfunction

        function void note_input(triangle_t t);
            pending_q.push_back(predict_geometry(t));
        endfunction

        function void check_result(logic [M_W-1:0] d, logic u);
            geom_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $realtime, d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[15:0] !== e.tag) begin
                $display("%0t: tag exp %h got %h", $realtime, e.tag, d[15:0]);
                errors++;
            end
            if (d[48:16] !== e.area) begin
                $display("%0t: area exp %0d got %0d", $realtime, e.area, d[48:16]);
                errors++;
            end
            for (int i = 0; i < 3; i++)
                if (d[49 + 16 * i +: 16] !== e.nrm[i]) begin
                    $display("%0t: normal[%0d] exp %h got %h", $realtime, i, e.nrm[i],
                             d[49 + 16 * i +: 16]);
                    errors++;
                end
            if (u !== e.degen) begin
                $display("%0t: degenerate exp %b got %b", $realtime, e.degen, u);
                errors++;
            end
        endfunction
    endclass

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           s_tvalid = 0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 0;
    logic [M_W-1:0] m_tdata;
    logic [0:0]     m_tuser;
    logic           cfg_valid = 0;
    logic           cfg_ready;
    logic [15:0]    cfg_data = '0;

    geom_scoreboard sb = new();
    bit             quiet = 0;
    bit             long_hold = 0;
    int             cycles = 0;

    triangle_normal_and_area_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);

    // receiver: short random stalls, plus one long hold-off on request
    int stall_left = 0;
    always @(posedge aclk) begin
        if (long_hold) begin
            long_hold = 0;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic send_triangle(triangle_t t);
        logic [S_W-1:0] d;
        d = '0;
        d[15:0] = t.tag;
        for (int i = 0; i < 9; i++) d[16 + 16 * i +: 16] = t.crd[i][15:0];
        s_tdata  <= d;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(t);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(bit [15:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.threshold = v;
        cfg_valid <= 0;
    endtask

    task automatic send_coords(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
        triangle_t t;
        t.tag = 16'($urandom_range(0, 65535));
        t.crd = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        send_triangle(t);
    endtask

    // half full-range, some small triangles near the threshold, some collinear
    task automatic send_random();
        triangle_t t;
        int        k, base, d[6];
        t.tag = 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) t.crd[i] = int'($urandom_range(0, 65535)) - 32768;
        if (k < 4) begin
            for (int i = 0; i < 3; i++) begin
                base = int'($urandom_range(0, 60000)) - 30000;
                t.crd[i]     = base;
                t.crd[3 + i] = base + int'($urandom_range(0, 600)) - 300;
                t.crd[6 + i] = base + int'($urandom_range(0, 600)) - 300;
            end
        end else if (k == 4) begin
            for (int i = 0; i < 3; i++) begin
                d[i] = int'($urandom_range(0, 200)) - 100;
                t.crd[i]     = int'($urandom_range(0, 20000)) - 10000;
                t.crd[3 + i] = t.crd[i] + d[i];
                t.crd[6 + i] = t.crd[i] + 3 * d[i];
            end
        end
        send_triangle(t);
    endtask

    initial begin
        bit [15:0] thr_list[6];
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part, threshold at reset value
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(32767, -32768, 100, 32767, -32768, 100, 32767, -32768, 100);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_coords(0, 0, 0, 0, 1, 0, 1, 0, 0);
        send_coords(0, 0, 0, 0, 0, 1, 0, 1, 0);
        send_coords(0, 0, 0, 1, 0, 0, 0, 0, 1);
        send_coords(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
        send_coords(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768);
        send_coords(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
        send_coords(0, 0, 0, 10, 20, 30, 30, 60, 90);
        send_coords(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
        send_coords(5, 5, 5, 6, 5, 5, 5, 5, 6);
        send_coords(100, -200, 300, -400, 500, -600, 700, 800, -900);
        write_threshold(16'hFFFF);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_coords(0, 0, 0, 255, 0, 0, 0, 257, 0);
        send_coords(0, 0, 0, 256, 0, 0, 0, 256, 0);
        write_threshold(16'd1);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_coords(0, 0, 0, 1, 0, 0, 0, 2, 0);

        thr_list = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd1,
                     16'($urandom_range(100, 40000)), 16'd0};
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_list[p]);
            if (p == 5) quiet = 1;
            for (int n = 0; n < 105; n++) begin
                if (p == 1 && n == 20) long_hold = 1;
                if (p == 2 && n == 50) drain();
                send_random();
            end
        end
        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/tnau_pkg.sv
hw/rtl/tnau_front.sv
hw/rtl/tnau_div.sv
hw/rtl/tnau_sqrt.sv
hw/rtl/triangle_normal_and_area_unit.sv
tb/sv/tb.sv
